>>> sv/joint_solution_dedup_selector_defines.svh
// Assertion macros for the joint solution dedup selector checker.
// No dependencies; included by the checker file only.
`ifndef JOINT_SOLUTION_DEDUP_SELECTOR_DEFINES_SVH
`define JOINT_SOLUTION_DEDUP_SELECTOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define JSDS_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |-> (c)) \
        else $error("joint solution dedup selector check failed");

// Next-cycle implication, disabled during reset.
`define JSDS_ASSERT_NXT(lbl, a, c) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |=> (c)) \
        else $error("joint solution dedup selector check failed");

`endif

>>> sv/jsds_pkg.sv
// Shared types, constants and helpers for the joint solution dedup selector.
// No dependencies; imported by every module of the block.
package jsds_pkg;

    localparam int MAX_KEPT_DEF    = 64;
    localparam int JOINT_COUNT_DEF = 12;
    localparam int ANGLE_BITS_DEF  = 16;
    localparam int SLOT_COUNT      = 12;
    localparam int HEIGHT_W        = 24;
    localparam int CNT_W           = 16;
    localparam int IN_DATA_W       = 232;
    localparam int OUT_DATA_W      = 72;
    localparam int PADDR_W         = 4;

    localparam logic [1:0] REG_DEDUP_ENABLE = 2'd0;
    localparam logic [1:0] REG_HEIGHT_THR   = 2'd1;
    localparam logic [1:0] REG_ANGLE_THR    = 2'd2;
    localparam logic [1:0] REG_OUTPUT_LIMIT = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic signed [HEIGHT_W-1:0] height_thr;
        logic [15:0]                angle_thr;
    } cmp_cfg_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
    endfunction

endpackage

>>> sv/jsds_store.sv
// Store of kept solutions: one row per entry, one write and one read port.
// Depends on jsds_pkg; read data is registered.
module jsds_store import jsds_pkg::*; #(
    parameter int DEPTH = MAX_KEPT_DEF,
    parameter int ROW_W = 228
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [ROW_W-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [ROW_W-1:0]                      rd_data
);

    logic [ROW_W-1:0] mem [DEPTH];
    logic [ROW_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/jsds_cmp.sv
// Similarity test of the candidate against one kept row: height gap and
// wrapped joint gaps in parallel. Depends on jsds_pkg.
module jsds_cmp import jsds_pkg::*; #(
    parameter int SLOTS = SLOT_COUNT,
    parameter int AB    = ANGLE_BITS_DEF
) (
    input  cmp_cfg_t                    cfg,
    input  logic signed [HEIGHT_W-1:0]  cand_h,
    input  logic [SLOTS*AB-1:0]         cand_ang,
    input  logic [SLOTS-1:0]            cand_mask,
    input  logic [SLOTS+HEIGHT_W+SLOTS*AB-1:0] kept_row,
    output logic                        similar
);

    localparam int CW = 25;
    localparam logic [AB:0] MOD  = (AB+1)'(1) << AB;
    localparam logic [AB:0] HALF = (AB+1)'(1) << (AB - 1);

    logic [SLOTS*AB-1:0]        kept_ang;
    logic signed [HEIGHT_W-1:0] kept_h;
    logic [SLOTS-1:0]           kept_mask;
    logic [SLOTS-1:0]           both;
    logic [SLOTS-1:0]           fail;
    logic signed [HEIGHT_W:0]   dh;
    logic [HEIGHT_W:0]          dh_abs;
    logic                       h_ok;

    assign kept_ang  = kept_row[SLOTS*AB-1:0];
    assign kept_h    = kept_row[SLOTS*AB +: HEIGHT_W];
    assign kept_mask = kept_row[SLOTS*AB+HEIGHT_W +: SLOTS];
    assign both      = cand_mask & kept_mask;

    for (genvar j = 0; j < SLOTS; j++) begin : g_joint
        logic [AB-1:0] d;
        logic [AB:0]   gap;
        assign d   = cand_ang[j*AB +: AB] - kept_ang[j*AB +: AB];
        assign gap = ({1'b0, d} > HALF) ? MOD - {1'b0, d} : {1'b0, d};
        assign fail[j] = both[j] && (CW'(gap) > CW'(cfg.angle_thr));
    end

    always_comb begin
        dh     = {cand_h[HEIGHT_W-1], cand_h} - {kept_h[HEIGHT_W-1], kept_h};
        dh_abs = dh[HEIGHT_W] ? (HEIGHT_W+1)'(-dh) : (HEIGHT_W+1)'(dh);
        h_ok   = cfg.height_thr[HEIGHT_W-1] || (dh_abs <= {1'b0, cfg.height_thr});
    end

    assign similar = h_ok && (both != '0) && (fail == '0);

endmodule

>>> sv/joint_solution_dedup_selector.sv
// Channel  | dir | transaction content
// s_*      | in  | tdata: lift_height, angles_low/mid/high, joint_present; tlast: batch_end
// m_*      | out | tdata: is_unique, is_selected, store_full, four batch counters
// APB      | in  | dedup_enable, height_threshold, angle_threshold, output_limit
// A solution is accepted only in the idle state and scanned against the kept store,
// read one row per cycle through its single read port; the read data is registered.
// With removal off the scan is skipped. Reset is synchronous, active low, and
// clears control state and counters; the store needs no clearing.
// A stalled result holds in the output register while the next solution is scanned.
module joint_solution_dedup_selector import jsds_pkg::*; #(
    parameter int MAX_KEPT    = MAX_KEPT_DEF,
    parameter int JOINT_COUNT = JOINT_COUNT_DEF,
    parameter int ANGLE_BITS  = ANGLE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // lift_height[23:0], angles_low[87:24], angles_mid[151:88],
    // angles_high[215:152], joint_present[227:216], zeros above
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // is_unique[0], is_selected[1], store_full[2], seen total[18:3],
    // unique total[34:19], dropped total[50:35], chosen total[66:51], zeros above
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int SLOTS = (JOINT_COUNT < SLOT_COUNT) ? JOINT_COUNT : SLOT_COUNT;
    localparam int AB    = ANGLE_BITS;
    localparam int ROW_W = SLOTS + HEIGHT_W + SLOTS * AB;
    localparam int KW    = $clog2(MAX_KEPT + 1);
    localparam int IDX_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

    // Configuration registers
    logic                       dedup_en_reg;
    logic signed [HEIGHT_W-1:0] height_thr_reg;
    logic [15:0]                angle_thr_reg;
    logic [6:0]                 out_limit_reg;
    logic                       cfg_wr;
    cmp_cfg_t                   cmp_cfg;
    logic                       enabled;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dedup_en_reg   <= 1'b0;
            height_thr_reg <= '1;
            angle_thr_reg  <= '0;
            out_limit_reg  <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_DEDUP_ENABLE: dedup_en_reg   <= pwdata[0];
                REG_HEIGHT_THR:   height_thr_reg <= pwdata[HEIGHT_W-1:0];
                REG_ANGLE_THR:    angle_thr_reg  <= pwdata[15:0];
                REG_OUTPUT_LIMIT: out_limit_reg  <= pwdata[6:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_DEDUP_ENABLE: prdata = {31'b0, dedup_en_reg};
            REG_HEIGHT_THR:   prdata = {{(32-HEIGHT_W){height_thr_reg[HEIGHT_W-1]}},
                                        height_thr_reg};
            REG_ANGLE_THR:    prdata = {16'b0, angle_thr_reg};
            REG_OUTPUT_LIMIT: prdata = {25'b0, out_limit_reg};
        endcase
    end

    assign cmp_cfg.height_thr = height_thr_reg;
    assign cmp_cfg.angle_thr  = angle_thr_reg;
    assign enabled = dedup_en_reg && (angle_thr_reg != '0);

    // Candidate capture, angles masked to the angle width
    logic [SLOTS*AB-1:0]        cand_ang_in;
    logic [SLOTS*AB-1:0]        cand_ang_reg;
    logic signed [HEIGHT_W-1:0] cand_h_reg;
    logic [SLOTS-1:0]           cand_mask_reg;
    logic                       cand_last_reg;
    logic                       s_acc;

    for (genvar j = 0; j < SLOTS; j++) begin : g_slot
        logic [23:0] wide;
        assign wide = {8'b0, s_tdata[HEIGHT_W + 16*j +: 16]};
        assign cand_ang_in[j*AB +: AB] = wide[AB-1:0];
    end

    assign s_acc = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            cand_ang_reg  <= cand_ang_in;
            cand_h_reg    <= s_tdata[HEIGHT_W-1:0];
            cand_mask_reg <= s_tdata[216 +: SLOTS];
            cand_last_reg <= s_tlast;
        end
    end

    // Control and batch state
    state_t           state_reg, state_next;
    logic [KW-1:0]    kept_reg, kept_next;
    logic [KW-1:0]    addr_reg, addr_next;
    logic             issue_reg, issue_next;
    logic             dup_reg, dup_next;
    logic [CNT_W-1:0] seen_reg, seen_next;
    logic [CNT_W-1:0] uniq_reg, uniq_next;
    logic [CNT_W-1:0] chosen_reg, chosen_next;
    logic             out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic             rd_en;
    logic             wr_en;
    logic [ROW_W-1:0] rd_row;
    logic             similar;
    logic             out_free;
    logic             sel;
    logic             full;
    logic [CNT_W-1:0] seen_inc, uniq_inc, chosen_inc, removed;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    jsds_store #(.DEPTH(MAX_KEPT), .ROW_W(ROW_W)) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (kept_reg[IDX_W-1:0]),
        .wr_data ({cand_mask_reg, cand_h_reg, cand_ang_reg}),
        .rd_en   (rd_en),
        .rd_addr (addr_reg[IDX_W-1:0]),
        .rd_data (rd_row)
    );

    jsds_cmp #(.SLOTS(SLOTS), .AB(AB)) u_cmp (
        .cfg       (cmp_cfg),
        .cand_h    (cand_h_reg),
        .cand_ang  (cand_ang_reg),
        .cand_mask (cand_mask_reg),
        .kept_row  (rd_row),
        .similar   (similar)
    );

    always_comb begin
        state_next     = state_reg;
        kept_next      = kept_reg;
        addr_next      = addr_reg;
        issue_next     = 1'b0;
        dup_next       = dup_reg;
        seen_next      = seen_reg;
        uniq_next      = uniq_reg;
        chosen_next    = chosen_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        sel            = 1'b0;
        full           = 1'b0;
        seen_inc       = sat_inc(seen_reg);
        uniq_inc       = uniq_reg;
        chosen_inc     = chosen_reg;
        removed        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    addr_next  = '0;
                    dup_next   = 1'b0;
                    state_next = enabled ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN: begin
                if (issue_reg && similar) begin
                    dup_next   = 1'b1;
                    state_next = ST_FINISH;
                end else if (addr_reg < kept_reg) begin
                    rd_en      = 1'b1;
                    issue_next = 1'b1;
                    addr_next  = addr_reg + 1'b1;
                end else if (!issue_reg) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!dup_reg) begin
                    uniq_inc = sat_inc(uniq_reg);
                    if (out_limit_reg == '0 || chosen_reg < {9'b0, out_limit_reg}) begin
                        sel        = 1'b1;
                        chosen_inc = sat_inc(chosen_reg);
                    end
                    full = enabled && (kept_reg >= KW'(MAX_KEPT));
                end
                removed = (seen_inc > uniq_inc) ? seen_inc - uniq_inc : '0;
                if (out_free) begin
                    wr_en          = enabled && !dup_reg && !full;
                    out_valid_next = 1'b1;
                    out_data_next  = {5'b0, chosen_inc, removed, uniq_inc, seen_inc,
                                      full, sel, !dup_reg};
                    state_next     = ST_IDLE;
                    if (cand_last_reg) begin
                        kept_next   = '0;
                        seen_next   = '0;
                        uniq_next   = '0;
                        chosen_next = '0;
                    end else begin
                        kept_next   = wr_en ? kept_reg + 1'b1 : kept_reg;
                        seen_next   = seen_inc;
                        uniq_next   = uniq_inc;
                        chosen_next = chosen_inc;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            kept_reg      <= '0;
            addr_reg      <= '0;
            issue_reg     <= 1'b0;
            dup_reg       <= 1'b0;
            seen_reg      <= '0;
            uniq_reg      <= '0;
            chosen_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            kept_reg      <= kept_next;
            addr_reg      <= addr_next;
            issue_reg     <= issue_next;
            dup_reg       <= dup_next;
            seen_reg      <= seen_next;
            uniq_reg      <= uniq_next;
            chosen_reg    <= chosen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

>>> sv/jsds_checker.sv
// Port-level checker for the joint solution dedup selector, bound to the top.
// Depends on jsds_pkg and joint_solution_dedup_selector_defines.svh.
`include "joint_solution_dedup_selector_defines.svh"
module jsds_checker import jsds_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // A stalled result transaction must stay offered.
    `JSDS_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    // Only a unique solution can be selected or flagged as not stored.
    `JSDS_ASSERT_IMP(a_sel_unique, m_tvalid && m_tdata[1], m_tdata[0])
    `JSDS_ASSERT_IMP(a_full_unique, m_tvalid && m_tdata[2], m_tdata[0])
    // The unique counter never runs ahead of the seen counter.
    `JSDS_ASSERT_IMP(a_cnt_order, m_tvalid, m_tdata[34:19] <= m_tdata[18:3])

endmodule

bind joint_solution_dedup_selector jsds_checker u_jsds_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
